[src/lphi_pkg.sv]
// Package for the linear probing hash insert unit.
// Holds the key width, the operation codes and the sequencer state type.
// No dependencies.
package lphi_pkg;

  localparam int KEY_W       = 34;
  localparam int SLOT_PORT_W = 4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_DATA,
    ST_HASH,
    ST_HOME,
    ST_RES_HASH,
    ST_PROBE,
    ST_WR_KEY
  } lphi_state_t;

endpackage

[src/lphi_mod.sv]
// Remainder unit: value mod TABLE_SIZE in three pipelined steps (fold, then two compare-subtract
// steps). Depends on lphi_pkg for the key width.
module lphi_mod #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lphi_pkg::KEY_W-1:0]    value,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] rem
);
  import lphi_pkg::*;

  localparam int SLOT_W  = $clog2(TABLE_SIZE);
  localparam int CHUNK_W = 4;
  localparam int N_CHUNK = (KEY_W + CHUNK_W - 1) / CHUNK_W;
  localparam int EXT_W   = N_CHUNK * CHUNK_W;
  // Each folded term is below 15 * TABLE_SIZE and there are N_CHUNK of them, so the sum stays
  // below 256 * TABLE_SIZE.
  localparam int SUM_W   = SLOT_W + 8;
  localparam logic [SUM_W-1:0] MOD_EXT = SUM_W'(TABLE_SIZE);

  // Weight of each key chunk: 2 to the power of its bit offset, reduced mod TABLE_SIZE.
  function automatic logic [N_CHUNK*SLOT_W-1:0] chunk_weights();
    logic [N_CHUNK*SLOT_W-1:0] v;
    int                        w;
    v = '0;
    w = 1;
    for (int i = 0; i < N_CHUNK; i++) begin
      v[i*SLOT_W +: SLOT_W] = SLOT_W'(w);
      for (int b = 0; b < CHUNK_W; b++) w = (w * 2) % TABLE_SIZE;
    end
    return v;
  endfunction

  localparam logic [N_CHUNK*SLOT_W-1:0] WEIGHTS = chunk_weights();

  logic [EXT_W-1:0]  val_ext;
  logic [SUM_W-1:0]  fold_sum;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  hi_red;
  logic [SUM_W-1:0]  mid;
  logic [SUM_W-1:0]  lo_red;
  logic [SLOT_W-1:0] r;
  logic              stage1, stage2;

  // Fold the key into a small sum with the same remainder.
  always_comb begin
    val_ext  = EXT_W'(value);
    fold_sum = '0;
    for (int i = 0; i < N_CHUNK; i++) begin
      fold_sum = fold_sum + SUM_W'(val_ext[i*CHUNK_W +: CHUNK_W]) *
                            SUM_W'(WEIGHTS[i*SLOT_W +: SLOT_W]);
    end
  end

  // Take off 128, 64, 32 and 16 times TABLE_SIZE where they fit.
  always_comb begin
    hi_red = acc;
    for (int j = 7; j >= 4; j--) begin
      if (hi_red >= (MOD_EXT << j)) hi_red = hi_red - (MOD_EXT << j);
    end
  end

  // Take off 8, 4, 2 and 1 times TABLE_SIZE; what is left is below TABLE_SIZE.
  always_comb begin
    lo_red = mid;
    for (int j = 3; j >= 0; j--) begin
      if (lo_red >= (MOD_EXT << j)) lo_red = lo_red - (MOD_EXT << j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start)  acc <= fold_sum;
    if (stage1) mid <= hi_red;
    if (stage2) r   <= lo_red[SLOT_W-1:0];
  end

  assign rem = r;

endmodule

[src/linear_probe_hash_insert_unit.sv]
// Top level of the linear probing hash insert unit: sequencer, slot memories, result register.
// Depends on lphi_pkg and lphi_mod.
//
// The unit holds an open-addressing table of TABLE_SIZE slots. Issue a transaction by raising
// start while busy is low. After reset the unit runs a clearing pass over the valid memory and
// stays busy until that pass is done. A read keeps busy high through the read data state. An
// insert into a full table never raises busy and reports full_res in the cycle right after it
// is accepted. Any other insert keeps busy high through the pipelined key mod TABLE_SIZE unit,
// a read of the home slot, the probe of each slot past it (one memory read per cycle) and the
// write of the key. In replacement mode, an occupied home slot also costs a pass through the
// remainder unit to hash its resident. A result shows in the first cycle after busy falls.
// Each result is shown for exactly one cycle with result_valid high. The receiver cannot
// stall it, so capture it in that cycle. A result cycle overlaps the first cycle in which the
// next transaction may be accepted. The replace_mode register is written over the cfg channel.
// That channel is always ready. Write it only while the unit is idle.
module linear_probe_hash_insert_unit #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func,
  input  logic [lphi_pkg::KEY_W-1:0]        key,
  input  logic [lphi_pkg::SLOT_PORT_W-1:0]  slot,
  output logic                              result_valid,
  output logic [lphi_pkg::SLOT_PORT_W-1:0]  placed_slot,
  output logic                              moved,
  output logic [lphi_pkg::SLOT_PORT_W-1:0]  moved_to_slot,
  output logic                              full_res,
  output logic [lphi_pkg::KEY_W-1:0]        read_key,
  output logic                              read_valid,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data
);
  import lphi_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TABLE_SIZE);

  lphi_state_t state, state_next;

  // Control registers.
  logic              replace_mode;
  logic [CNT_W-1:0]  used_count, used_count_next;
  logic [SLOT_W-1:0] clr, clr_next;

  // Working registers for the transaction in flight.
  logic [SLOT_W-1:0] ptr, ptr_next;
  logic [SLOT_W-1:0] home, home_next;
  logic [SLOT_W-1:0] place, place_next;
  logic [SLOT_W-1:0] moved_to, moved_to_next;
  logic [KEY_W-1:0]  key_q, key_q_next;
  logic [KEY_W-1:0]  resident, resident_next;
  logic              disp, disp_next;
  logic              rd_ok, rd_ok_next;

  // Slot memories: keys have no reset, valid bits are cleared by the pass after reset.
  logic [KEY_W-1:0]  key_mem [TABLE_SIZE];
  logic              valid_mem [TABLE_SIZE];
  logic [KEY_W-1:0]  rd_key_q;
  logic              rd_valid_q;
  logic              kw_en, vw_en, w_valid;
  logic [SLOT_W-1:0] w_addr;
  logic [KEY_W-1:0]  w_key;

  // Remainder unit.
  logic              mod_start, mod_done;
  logic [KEY_W-1:0]  mod_value;
  logic [SLOT_W-1:0] mod_rem;

  // Result staging.
  logic                   res_we;
  logic [SLOT_PORT_W-1:0] res_placed, res_moved_to;
  logic                   res_moved, res_full, res_rvalid;
  logic [KEY_W-1:0]       res_rkey;

  logic              slot_in_range;
  logic [SLOT_W-1:0] slot_idx;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // A read slot beyond the table reads as an empty slot; index 0 keeps the address legal.
  assign slot_in_range = ({28'd0, slot} < 32'(TABLE_SIZE));
  assign slot_idx      = slot_in_range ? SLOT_W'(slot) : '0;

  lphi_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (mod_value),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == LAST_SLOT) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_READ) begin
            state_next = ST_RD_DATA;
          end else if (used_count != FULL_CNT) begin
            state_next = ST_HASH;
          end
        end
      end
      ST_RD_DATA: state_next = ST_IDLE;
      ST_HASH: begin
        if (mod_done) state_next = ST_HOME;
      end
      ST_HOME: begin
        if (!rd_valid_q) begin
          state_next = ST_WR_KEY;
        end else if (replace_mode) begin
          state_next = ST_RES_HASH;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_RES_HASH: begin
        if (mod_done) state_next = ST_PROBE;
      end
      ST_PROBE: begin
        if (!rd_valid_q) state_next = ST_WR_KEY;
      end
      ST_WR_KEY: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control and register next values.
  always_comb begin
    clr_next        = clr;
    used_count_next = used_count;
    ptr_next        = ptr;
    home_next       = home;
    place_next      = place;
    moved_to_next   = moved_to;
    key_q_next      = key_q;
    resident_next   = resident;
    disp_next       = disp;
    rd_ok_next      = rd_ok;
    mod_start       = 1'b0;
    mod_value       = key;
    kw_en           = 1'b0;
    vw_en           = 1'b0;
    w_addr          = ptr;
    w_key           = resident;
    w_valid         = 1'b1;
    res_we          = 1'b0;
    res_placed      = '0;
    res_moved       = 1'b0;
    res_moved_to    = '0;
    res_full        = 1'b0;
    res_rkey        = '0;
    res_rvalid      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        vw_en    = 1'b1;
        w_addr   = clr;
        w_valid  = 1'b0;
        clr_next = clr + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_READ) begin
            ptr_next   = slot_idx;
            rd_ok_next = slot_in_range;
          end else if (used_count == FULL_CNT) begin
            res_we   = 1'b1;
            res_full = 1'b1;
          end else begin
            key_q_next = key;
            mod_start  = 1'b1;
            mod_value  = key;
          end
        end
      end
      ST_RD_DATA: begin
        res_we     = 1'b1;
        res_rvalid = rd_ok & rd_valid_q;
        res_rkey   = (rd_ok & rd_valid_q) ? rd_key_q : '0;
      end
      ST_HASH: begin
        if (mod_done) begin
          home_next = mod_rem;
          ptr_next  = mod_rem;
        end
      end
      ST_HOME: begin
        disp_next = 1'b0;
        if (!rd_valid_q) begin
          place_next = home;
        end else if (replace_mode) begin
          resident_next = rd_key_q;
          mod_start     = 1'b1;
          mod_value     = rd_key_q;
        end else begin
          ptr_next = (ptr == LAST_SLOT) ? '0 : ptr + 1'b1;
        end
      end
      ST_RES_HASH: begin
        if (mod_done) begin
          disp_next = (mod_rem != home);
          ptr_next  = (home == LAST_SLOT) ? '0 : home + 1'b1;
        end
      end
      ST_PROBE: begin
        if (!rd_valid_q) begin
          if (disp) begin
            // The misplaced resident moves to this free slot, the new key takes home.
            kw_en         = 1'b1;
            vw_en         = 1'b1;
            w_addr        = ptr;
            w_key         = resident;
            moved_to_next = ptr;
            place_next    = home;
          end else begin
            place_next = ptr;
          end
        end else begin
          ptr_next = (ptr == LAST_SLOT) ? '0 : ptr + 1'b1;
        end
      end
      ST_WR_KEY: begin
        kw_en           = 1'b1;
        vw_en           = 1'b1;
        w_addr          = place;
        w_key           = key_q;
        used_count_next = used_count + 1'b1;
        res_we          = 1'b1;
        res_placed      = SLOT_PORT_W'(place);
        res_moved       = disp;
        res_moved_to    = disp ? SLOT_PORT_W'(moved_to) : '0;
      end
      default: begin
        clr_next = clr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr          <= '0;
      used_count   <= '0;
      replace_mode <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      clr          <= clr_next;
      used_count   <= used_count_next;
      result_valid <= res_we;
      if (cfg_valid && cfg_ready) replace_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    home     <= home_next;
    place    <= place_next;
    moved_to <= moved_to_next;
    key_q    <= key_q_next;
    resident <= resident_next;
    disp     <= disp_next;
    rd_ok    <= rd_ok_next;
    if (res_we) begin
      placed_slot   <= res_placed;
      moved         <= res_moved;
      moved_to_slot <= res_moved_to;
      full_res      <= res_full;
      read_key      <= res_rkey;
      read_valid    <= res_rvalid;
    end
  end

  // The read address is the next probe pointer, so the registered data matches ptr.
  always_ff @(posedge clk) begin
    if (kw_en) key_mem[w_addr] <= w_key;
    rd_key_q <= key_mem[ptr_next];
  end

  always_ff @(posedge clk) begin
    if (vw_en) valid_mem[w_addr] <= w_valid;
    rd_valid_q <= valid_mem[ptr_next];
  end

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= FULL_CNT)
    else $error("occupied slot count above table size");

  a_count_on_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR_KEY) |=> (used_count == $past(used_count) + 1'b1))
    else $error("insert did not bump the occupied slot count");

  a_full_drops: assert property (@(posedge clk) disable iff (rst)
    (result_valid && full_res) |-> (!moved && (placed_slot == '0) && !read_valid))
    else $error("full table result carries placement data");
`endif

endmodule

[dv/tb_linear_probe_hash_insert_unit.sv]
// Self-checking testbench for the linear probing hash insert unit.
// A scoreboard class keeps its own copy of the slot table and checks every strobed result.
// Depends on lphi_pkg and linear_probe_hash_insert_unit.
`timescale 1ns / 100ps

module tb_linear_probe_hash_insert_unit;
  import lphi_pkg::*;

  localparam int TABLE_SIZE   = 16;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  // Even a run of nothing but the slowest inserts, each behind the longest idle burst, stays far
  // below this limit.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1030;
  // The final stretch of random transactions runs back to back, with no idle cycles.
  localparam int CALM_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 40;

  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [SLOT_PORT_W-1:0] slot_t;

  // The field order matches the concatenation of the result ports in the monitor below.
  typedef struct packed {
    slot_t placed_slot;
    logic  moved;
    slot_t moved_to_slot;
    logic  full_res;
    key_t  read_key;
    logic  read_valid;
  } hash_outcome_t;

  // The scoreboard holds its own copy of the table and the mode. For each accepted transaction
  // it works out the result that the unit should report.
  class hash_table_scoreboard;
    key_t          slot_keys[TABLE_SIZE];
    bit            slot_used[TABLE_SIZE];
    int            used_count;
    bit            replace_mode;
    hash_outcome_t expected_outcomes[$];
    int            mismatches;
    int            inserts_placed;
    int            displacements;
    int            full_drops;
    int            slot_reads;
    int            mode_writes;

    function new();
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_keys[i] = '0;
        slot_used[i] = 1'b0;
      end
      used_count     = 0;
      replace_mode   = 1'b0;
      mismatches     = 0;
      inserts_placed = 0;
      displacements  = 0;
      full_drops     = 0;
      slot_reads     = 0;
      mode_writes    = 0;
    endfunction

    function int home_of(key_t k);
      return int'(k % TABLE_SIZE);
    endfunction

    function int next_slot(int s);
      return (s + 1 >= TABLE_SIZE) ? 0 : s + 1;
    endfunction

    // Walks forward from start, wrapping, to the first free slot. The table is known not to
    // be full whenever this is called.
    function int first_free(int start);
      int s;
      s = start;
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (!slot_used[s]) return s;
        s = next_slot(s);
      end
      return start;
    endfunction

    function void note_transaction(logic op, key_t k, slot_t s);
      hash_outcome_t r;
      int            h;
      int            dst;
      int            place;
      r = '0;
      if (op == FUNC_READ) begin
        slot_reads++;
        if (int'(s) < TABLE_SIZE && slot_used[s]) begin
          r.read_valid = 1'b1;
          r.read_key   = slot_keys[s];
        end
      end else if (used_count >= TABLE_SIZE) begin
        // A full table drops the key and leaves every slot alone.
        r.full_res = 1'b1;
        full_drops++;
      end else begin
        h = home_of(k);
        if (!slot_used[h]) begin
          place = h;
        end else if (replace_mode && home_of(slot_keys[h]) != h) begin
          // The resident does not belong here, so it moves on and the new key takes its place.
          dst            = first_free(next_slot(h));
          slot_keys[dst] = slot_keys[h];
          slot_used[dst] = 1'b1;
          r.moved         = 1'b1;
          r.moved_to_slot = slot_t'(dst);
          place = h;
          displacements++;
        end else begin
          place = first_free(h);
        end
        slot_keys[place] = k;
        slot_used[place] = 1'b1;
        used_count++;
        r.placed_slot = slot_t'(place);
        inserts_placed++;
      end
      expected_outcomes.push_back(r);
    endfunction

    function void compare_field(string name, key_t exp_v, key_t got_v);
      if (exp_v !== got_v) begin
        mismatches++;
        if (mismatches <= 40)
          $display("time %0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(hash_outcome_t got);
      hash_outcome_t exp_r;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("time %0t: result with no transaction pending, expected none actual %0h",
                   $time, got);
        return;
      end
      exp_r = expected_outcomes.pop_front();
      compare_field("placed_slot",   key_t'(exp_r.placed_slot),   key_t'(got.placed_slot));
      compare_field("moved",         key_t'(exp_r.moved),         key_t'(got.moved));
      compare_field("moved_to_slot", key_t'(exp_r.moved_to_slot), key_t'(got.moved_to_slot));
      compare_field("full_res",      key_t'(exp_r.full_res),      key_t'(got.full_res));
      compare_field("read_key",      exp_r.read_key,              got.read_key);
      compare_field("read_valid",    key_t'(exp_r.read_valid),    key_t'(got.read_valid));
    endfunction
  endclass

  // Every input of the unit starts at a known value, with reset asserted.
  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  start     = 1'b0;
  logic  func      = FUNC_INSERT;
  key_t  key       = '0;
  slot_t slot      = '0;
  logic  cfg_valid = 1'b0;
  logic  cfg_data  = 1'b0;

  logic  busy;
  logic  result_valid;
  slot_t placed_slot;
  logic  moved;
  slot_t moved_to_slot;
  logic  full_res;
  key_t  read_key;
  logic  read_valid;
  logic  cfg_ready;

  int    cycle_count = 0;

  hash_table_scoreboard sb;

  linear_probe_hash_insert_unit #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .key          (key),
    .slot         (slot),
    .result_valid (result_valid),
    .placed_slot  (placed_slot),
    .moved        (moved),
    .moved_to_slot(moved_to_slot),
    .full_res     (full_res),
    .read_key     (read_key),
    .read_valid   (read_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("time %0t: run stopped after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result monitor. The unit shows each result for exactly one cycle, and nothing can hold it
  // off. The ports are sampled in the active region of the edge, so the values are the ones
  // from before the edge, as the receiver would see them.
  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_result({placed_slot, moved, moved_to_slot, full_res, read_key, read_valid});
  end

  function automatic key_t rand_key();
    key_t k;
    k[31:0]  = $urandom();
    k[33:32] = 2'($urandom_range(0, 3));
    return k;
  endfunction

  // Drives one transaction and holds it until the unit takes it. Start is left high, so that a
  // following transaction can go out on the very next edge. The scoreboard notes the
  // transaction at the edge where start is high and busy is low.
  task automatic issue(logic op, key_t k, slot_t s);
    start <= 1'b1;
    func  <= op;
    key   <= k;
    slot  <= s;
    do @(posedge clk); while (busy);
    sb.note_transaction(op, k, s);
  endtask

  // Stops issuing and waits until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // The mode register is only written while the unit is idle. Every transaction returns a
  // result, so an empty scoreboard means that the unit is idle.
  task automatic write_mode(bit m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.replace_mode = m;
    sb.mode_writes++;
  endtask

  initial begin : stimulus
    int    done;
    int    phase_len;
    bit    gaps_on;
    slot_t s;

    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    // The unit clears its valid bits after reset and is busy until that is done.
    do @(posedge clk); while (busy);

    // Plain probing. The key of all ones and the key of zero are the extremes of the key. The
    // duplicate of all ones finds slot 15 taken, wraps past slot 0 and lands in slot 1, so
    // slot 1 now holds a key whose home is elsewhere. Key 16 also homes at slot 0 and probes.
    write_mode(1'b0);
    issue(FUNC_INSERT, key_t'(0), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(34'h3_FFFF_FFFF), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(34'h3_FFFF_FFFF), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(16), slot_t'($urandom_range(0, 15)));
    issue(FUNC_READ, rand_key(), slot_t'(1));

    // Replacement mode. Key 17 evicts the misplaced resident of slot 1. Key 33 then finds a
    // resident that is at home and probes instead. Key 2 evicts key 16 from slot 2.
    write_mode(1'b1);
    issue(FUNC_INSERT, key_t'(17), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(33), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(2), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(14), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(30), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(6), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(23), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(40), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(34'h2_0000_000C), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(34'h2_AAAA_AAAA), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(34'h1_5555_5555), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, key_t'(13), slot_t'($urandom_range(0, 15)));
    // Filling the table takes sixteen inserts. Any that fell short of a fresh slot show up
    // here as further placed keys rather than as drops, and the scoreboard follows either way.
    issue(FUNC_INSERT, key_t'(34'h3_FFFF_FFFF), slot_t'($urandom_range(0, 15)));
    issue(FUNC_INSERT, rand_key(), slot_t'($urandom_range(0, 15)));
    issue(FUNC_READ, rand_key(), slot_t'(0));
    issue(FUNC_READ, rand_key(), slot_t'(15));

    // Random phases. Each phase before the final stretch starts with a full pause, and most
    // also rewrite the mode. Reads only go to slots that hold a key, because the key store is
    // undefined until it is written.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 160);
      gaps_on   = ($urandom_range(0, 3) != 0);
      if (done < RANDOM_ITEMS - CALM_ITEMS) begin
        if ($urandom_range(0, 2) != 0)
          write_mode(1'($urandom_range(0, 1)));
        else
          drain();
      end
      for (int i = 0; i < phase_len && done < RANDOM_ITEMS; i++) begin
        if (sb.used_count == 0 || $urandom_range(0, 1) == 0) begin
          issue(FUNC_INSERT, rand_key(), slot_t'($urandom_range(0, 15)));
        end else begin
          do s = slot_t'($urandom_range(0, TABLE_SIZE - 1)); while (!sb.slot_used[s]);
          issue(FUNC_READ, rand_key(), s);
        end
        done++;
        if (gaps_on && done < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 2) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
      end
    end

    // Wait for the last results, then watch a little longer for any stray strobe.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d stored keys, %0d displacements, %0d drops on a full table,",
             sb.inserts_placed, sb.displacements, sb.full_drops);
    $display("and %0d slot reads, across %0d mode register writes.",
             sb.slot_reads, sb.mode_writes);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
